/* hdl/pps_pkg.sv */
package pps_pkg;

	localparam int unsigned CNT_W = 32;
	localparam int unsigned PRIO_W = 7;
	localparam int unsigned NICE_W = 4;
	localparam logic [PRIO_W-1:0] PRIO_MAX = 7'd100;
	localparam logic [PRIO_W-1:0] DEF_PRIO_RST = 7'd60;
	localparam logic [NICE_W-1:0] DEF_NICE_RST = 4'd5;
	localparam logic [8:0] NICE_BIAS = 9'd5;

	typedef enum logic [2:0] {
		MODE_TICK  = 3'd0,
		MODE_ALLOC = 3'd1,
		MODE_PICK  = 3'd2,
		MODE_REL   = 3'd3,
		MODE_WAKE  = 3'd4,
		MODE_SETP  = 3'd5,
		MODE_FREE  = 3'd6,
		MODE_NOP   = 3'd7
	} mode_t;

	typedef enum logic [2:0] {
		SS_UNUSED   = 3'd0,
		SS_RUNNABLE = 3'd2,
		SS_RUNNING  = 3'd3,
		SS_SLEEPING = 3'd4,
		SS_EXITED   = 3'd5
	} sstate_t;

	typedef enum logic [1:0] {
		NXT_RUNNABLE = 2'd0,
		NXT_SLEEPING = 2'd1,
		NXT_EXITED   = 2'd2,
		NXT_BAD      = 2'd3
	} nxt_t;

	typedef enum logic [1:0] {
		RES_DONE  = 2'd0,
		RES_NONE  = 2'd1,
		RES_WRONG = 2'd2
	} res_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_DECIDE,
		FSM_DIV,
		FSM_APPLY,
		FSM_FINISH
	} fsm_t;

	typedef enum logic {
		REG_DEF_PRIO = 1'b0,
		REG_DEF_NICE = 1'b1
	} reg_t;

	typedef struct packed {
		sstate_t           st;
		logic [PRIO_W-1:0] prio;
		logic [NICE_W-1:0] nice;
		logic [CNT_W-1:0]  run_count;
		logic [CNT_W-1:0]  created;
		logic [CNT_W-1:0]  sleep_ticks;
		logic [CNT_W-1:0]  run_ticks;
	} slot_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic logic signed [8:0] raw_prio(input logic [PRIO_W-1:0] p,
			input logic [NICE_W-1:0] n);
		raw_prio = $signed({2'b00, p}) - $signed({5'b00000, n}) + $signed(NICE_BIAS);
	endfunction

	function automatic logic [PRIO_W-1:0] dyn_prio(input logic [PRIO_W-1:0] p,
			input logic [NICE_W-1:0] n);
		logic signed [8:0] d;
		d = raw_prio(p, n);
		if (d < 0) begin
			dyn_prio = '0;
		end else if (d > $signed({2'b00, PRIO_MAX})) begin
			dyn_prio = PRIO_MAX;
		end else begin
			dyn_prio = d[PRIO_W-1:0];
		end
	endfunction

endpackage

/* hdl/priority_process_scheduler.sv */
// Channel   Handshake                        Payload
// command   start, busy (accept: start&!busy) mode, slot, new_priority, next_status
// result    done, one cycle, no back-pressure status, chosen_slot, old_priority, preempt
// config    psel/penable/pwrite/pready       paddr, pwdata, prdata
// The slot ring of cells rotates one slot per cycle past a head during scan and apply.
// Tick, allocate, wake, set priority, free and mode 7 make one rotation of the ring,
// then decide and finish. Pick may add a second rotation marking the best slot running;
// release may add a four-step divider and a second rotation writing the new niceness.
// Reset marks every slot unused, clears the tick count and loads default registers.
// Results cannot be stalled; busy stays high until the result strobe.
module priority_process_scheduler #(
	parameter int unsigned SLOT_COUNT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  mode,
	input  logic [5:0]  slot,
	input  logic [6:0]  new_priority,
	input  logic [1:0]  next_status,
	output logic        done,
	output logic [1:0]  status,
	output logic [5:0]  chosen_slot,
	output logic [6:0]  old_priority,
	output logic        preempt,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int unsigned IW = (SLOT_COUNT > 2) ? $clog2(SLOT_COUNT) : 1;
	localparam int unsigned CW = (IW > 6) ? IW : 6;
	localparam logic [IW-1:0] LAST = IW'(SLOT_COUNT - 1);

	pps_pkg::fsm_t state_q, state_nx;
	pps_pkg::mode_t mode_q;
	logic [5:0]  slot_q;
	logic [6:0]  newp_q;
	pps_pkg::nxt_t nxt_q;
	logic [IW-1:0] idx_q;
	logic [6:0]  def_prio_q;
	logic [3:0]  def_nice_q;
	logic [31:0] tick_q;

	logic        ok_q, found_q;
	logic [IW-1:0] best_q;
	logic [6:0]  bp_q;
	logic [31:0] brc_q, bct_q;
	logic [31:0] sl_q;
	logic [32:0] sum_q;
	logic [6:0]  oldp_q;
	logic        pre_q;

	pps_pkg::slot_t cell_q [SLOT_COUNT];
	pps_pkg::slot_t head, upd;
	logic shift, hit, is_best, cand, div_go, div_done;
	logic [3:0] quot;
	logic [6:0] hd;
	logic cfg_wr;

	assign head = cell_q[0];
	assign hit = CW'(slot_q) == CW'(idx_q);
	assign is_best = idx_q == best_q;
	assign shift = (state_q == pps_pkg::FSM_SCAN) || (state_q == pps_pkg::FSM_APPLY);
	assign hd = pps_pkg::dyn_prio(head.prio, head.nice);
	assign cand = (head.st == pps_pkg::SS_RUNNABLE) && (!found_q || hd < bp_q ||
		(hd == bp_q && (head.run_count < brc_q ||
		(head.run_count == brc_q && head.created < bct_q))));

	genvar k;
	generate
		for (k = 0; k < SLOT_COUNT; k++) begin : g_ring
			pps_cell u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.shift(shift),
				.din((k == SLOT_COUNT - 1) ? upd : cell_q[(k + 1) % SLOT_COUNT]),
				.q(cell_q[k])
			);
		end
	endgenerate

	pps_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.go(div_go),
		.sleep_ticks(sl_q),
		.total(sum_q),
		.quot(quot),
		.done(div_done)
	);

	always_comb begin
		upd = head;
		if (state_q == pps_pkg::FSM_SCAN) begin
			unique case (mode_q)
				pps_pkg::MODE_TICK: begin
					if (head.st == pps_pkg::SS_RUNNING) begin
						upd.run_ticks = pps_pkg::sat_inc(head.run_ticks);
					end else if (head.st == pps_pkg::SS_SLEEPING) begin
						upd.sleep_ticks = pps_pkg::sat_inc(head.sleep_ticks);
					end
				end
				pps_pkg::MODE_ALLOC: begin
					if (head.st == pps_pkg::SS_UNUSED && !ok_q) begin
						upd.st = pps_pkg::SS_RUNNABLE;
						upd.prio = def_prio_q;
						upd.nice = def_nice_q;
						upd.run_count = '0;
						upd.created = tick_q;
						upd.sleep_ticks = '0;
						upd.run_ticks = '0;
					end
				end
				pps_pkg::MODE_REL: begin
					if (hit && head.st == pps_pkg::SS_RUNNING) begin
						unique case (nxt_q)
							pps_pkg::NXT_RUNNABLE: upd.st = pps_pkg::SS_RUNNABLE;
							pps_pkg::NXT_SLEEPING: upd.st = pps_pkg::SS_SLEEPING;
							pps_pkg::NXT_EXITED:   upd.st = pps_pkg::SS_EXITED;
							default:               upd.st = head.st;
						endcase
					end
				end
				pps_pkg::MODE_WAKE: begin
					if (hit && head.st == pps_pkg::SS_SLEEPING) begin
						upd.st = pps_pkg::SS_RUNNABLE;
					end
				end
				pps_pkg::MODE_SETP: begin
					if (hit && head.st != pps_pkg::SS_UNUSED) begin
						upd.prio = newp_q;
						upd.nice = def_nice_q;
						upd.sleep_ticks = '0;
						upd.run_ticks = '0;
					end
				end
				pps_pkg::MODE_FREE: begin
					if (hit && head.st != pps_pkg::SS_UNUSED) begin
						upd.st = pps_pkg::SS_UNUSED;
					end
				end
				default: upd = head;
			endcase
		end else if (state_q == pps_pkg::FSM_APPLY) begin
			if (mode_q == pps_pkg::MODE_PICK && is_best) begin
				upd.st = pps_pkg::SS_RUNNING;
				upd.run_count = pps_pkg::sat_inc(head.run_count);
			end else if (mode_q == pps_pkg::MODE_REL && hit) begin
				upd.nice = quot;
			end
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			pps_pkg::FSM_IDLE: begin
				if (start) begin
					state_nx = pps_pkg::FSM_SCAN;
				end
			end
			pps_pkg::FSM_SCAN: begin
				if (idx_q == LAST) begin
					state_nx = pps_pkg::FSM_DECIDE;
				end
			end
			pps_pkg::FSM_DECIDE: begin
				if (mode_q == pps_pkg::MODE_PICK && found_q) begin
					state_nx = pps_pkg::FSM_APPLY;
				end else if (mode_q == pps_pkg::MODE_REL && ok_q && sum_q != '0) begin
					state_nx = pps_pkg::FSM_DIV;
				end else begin
					state_nx = pps_pkg::FSM_FINISH;
				end
			end
			pps_pkg::FSM_DIV: begin
				if (div_done) begin
					state_nx = pps_pkg::FSM_APPLY;
				end
			end
			pps_pkg::FSM_APPLY: begin
				if (idx_q == LAST) begin
					state_nx = pps_pkg::FSM_FINISH;
				end
			end
			pps_pkg::FSM_FINISH: state_nx = pps_pkg::FSM_IDLE;
			default: state_nx = pps_pkg::FSM_IDLE;
		endcase
	end

	always_comb begin
		busy = state_q != pps_pkg::FSM_IDLE;
		done = state_q == pps_pkg::FSM_FINISH;
		div_go = (state_q == pps_pkg::FSM_DECIDE) && (state_nx == pps_pkg::FSM_DIV);
		status = pps_pkg::RES_DONE;
		chosen_slot = '0;
		old_priority = '0;
		preempt = 1'b0;
		if (done) begin
			unique case (mode_q)
				pps_pkg::MODE_ALLOC, pps_pkg::MODE_PICK: begin
					if (ok_q) begin
						chosen_slot = 6'(best_q);
					end else begin
						status = pps_pkg::RES_NONE;
					end
				end
				pps_pkg::MODE_REL, pps_pkg::MODE_WAKE, pps_pkg::MODE_FREE: begin
					if (!ok_q) begin
						status = pps_pkg::RES_WRONG;
					end
				end
				pps_pkg::MODE_SETP: begin
					if (ok_q) begin
						old_priority = oldp_q;
						preempt = pre_q;
					end else begin
						status = pps_pkg::RES_WRONG;
					end
				end
				default: status = pps_pkg::RES_DONE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pps_pkg::FSM_IDLE;
			idx_q <= '0;
			tick_q <= '0;
		end else begin
			state_q <= state_nx;
			if (shift) begin
				idx_q <= (idx_q == LAST) ? '0 : idx_q + 1'b1;
			end
			if (state_q == pps_pkg::FSM_IDLE && start &&
					pps_pkg::mode_t'(mode) == pps_pkg::MODE_TICK) begin
				tick_q <= pps_pkg::sat_inc(tick_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == pps_pkg::FSM_IDLE && start) begin
			mode_q <= pps_pkg::mode_t'(mode);
			slot_q <= slot;
			newp_q <= new_priority;
			nxt_q <= pps_pkg::nxt_t'(next_status);
			ok_q <= 1'b0;
			found_q <= 1'b0;
			sum_q <= '0;
		end else if (state_q == pps_pkg::FSM_SCAN) begin
			unique case (mode_q)
				pps_pkg::MODE_ALLOC: begin
					if (head.st == pps_pkg::SS_UNUSED && !ok_q) begin
						ok_q <= 1'b1;
						best_q <= idx_q;
					end
				end
				pps_pkg::MODE_PICK: begin
					if (cand) begin
						ok_q <= 1'b1;
						found_q <= 1'b1;
						best_q <= idx_q;
						bp_q <= hd;
						brc_q <= head.run_count;
						bct_q <= head.created;
					end
				end
				pps_pkg::MODE_REL: begin
					if (hit && head.st == pps_pkg::SS_RUNNING && nxt_q != pps_pkg::NXT_BAD) begin
						ok_q <= 1'b1;
						sl_q <= head.sleep_ticks;
						sum_q <= {1'b0, head.sleep_ticks} + {1'b0, head.run_ticks};
					end
				end
				pps_pkg::MODE_WAKE: begin
					if (hit && head.st == pps_pkg::SS_SLEEPING) begin
						ok_q <= 1'b1;
					end
				end
				pps_pkg::MODE_SETP: begin
					if (hit && head.st != pps_pkg::SS_UNUSED) begin
						ok_q <= 1'b1;
						oldp_q <= head.prio;
						pre_q <= $signed({2'b00, newp_q}) < pps_pkg::raw_prio(head.prio, head.nice);
					end
				end
				pps_pkg::MODE_FREE: begin
					if (hit && head.st != pps_pkg::SS_UNUSED) begin
						ok_q <= 1'b1;
					end
				end
				default: ok_q <= ok_q;
			endcase
		end
	end

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			def_prio_q <= pps_pkg::DEF_PRIO_RST;
			def_nice_q <= pps_pkg::DEF_NICE_RST;
		end else if (cfg_wr) begin
			unique case (pps_pkg::reg_t'(paddr[2]))
				pps_pkg::REG_DEF_PRIO: def_prio_q <= pwdata[6:0];
				pps_pkg::REG_DEF_NICE: def_nice_q <= pwdata[3:0];
				default: def_prio_q <= def_prio_q;
			endcase
		end
	end

	always_comb begin
		unique case (pps_pkg::reg_t'(paddr[2]))
			pps_pkg::REG_DEF_PRIO: prdata = {25'd0, def_prio_q};
			pps_pkg::REG_DEF_NICE: prdata = {28'd0, def_nice_q};
			default: prdata = '0;
		endcase
	end

`ifndef ASSERT_OFF
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result strobe outside a transaction");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted transaction not started");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");
	a_ring_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> idx_q == '0) else $error("slot ring misaligned while idle");
`endif

endmodule

/* hdl/pps_cell.sv */
module pps_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           shift,
	input  pps_pkg::slot_t din,
	output pps_pkg::slot_t q
);

	pps_pkg::slot_t data_q;
	pps_pkg::sstate_t st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= pps_pkg::SS_UNUSED;
		end else if (shift) begin
			st_q <= din.st;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= din;
		end
	end

	always_comb begin
		q = data_q;
		q.st = st_q;
	end

endmodule

/* hdl/pps_div.sv */
module pps_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [31:0] sleep_ticks,
	input  logic [32:0] total,
	output logic [3:0]  quot,
	output logic        done
);

	logic [35:0] rem_q;
	logic [32:0] den_q;
	logic [3:0]  quot_q;
	logic [1:0]  bit_q;
	logic        run_q;
	logic [36:0] trial;
	logic        fits;

	assign trial = 37'(den_q) << bit_q;
	assign fits = {1'b0, rem_q} >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			bit_q <= '0;
		end else if (go) begin
			run_q <= 1'b1;
			bit_q <= 2'd3;
		end else if (run_q) begin
			bit_q <= bit_q - 1'b1;
			if (bit_q == 2'd0) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q  <= {1'b0, sleep_ticks, 3'b000} + {3'b000, sleep_ticks, 1'b0};
			den_q  <= total;
			quot_q <= '0;
		end else if (run_q && fits) begin
			rem_q <= 36'({1'b0, rem_q} - trial);
			quot_q[bit_q] <= 1'b1;
		end
	end

	assign quot = quot_q;
	assign done = run_q && (bit_q == 2'd0);

endmodule

/* test/tb.sv */
module tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned NSLOT = 64;
	localparam int unsigned WATCH_LIMIT = 20000;

	typedef struct packed {
		logic [1:0] status;
		logic [5:0] chosen;
		logic [6:0] oldp;
		logic       pre;
	} sched_res_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  mode;
	logic [5:0]  slot;
	logic [6:0]  new_priority;
	logic [1:0]  next_status;
	logic        done;
	logic [1:0]  status;
	logic [5:0]  chosen_slot;
	logic [6:0]  old_priority;
	logic        preempt;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	logic [2:0]  m_st [NSLOT];
	logic [6:0]  m_prio [NSLOT];
	logic [3:0]  m_nice [NSLOT];
	logic [31:0] m_runs [NSLOT];
	logic [31:0] m_made [NSLOT];
	logic [31:0] m_slp [NSLOT];
	logic [31:0] m_run [NSLOT];
	logic [31:0] m_ticks;
	logic [6:0]  m_def_prio;
	logic [3:0]  m_def_nice;

	sched_res_t  pending_res[$];
	int          fail_count = 0;
	int          cfg_fail = 0;
	int          idle_cycles = 0;

	priority_process_scheduler i_dut (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [31:0] sinc(logic [31:0] v);
		return (v == '1) ? v : v + 1;
	endfunction

	function automatic int dprio(int i);
		int d;
		d = int'(m_prio[i]) - int'(m_nice[i]) + 5;
		if (d < 0) d = 0;
		if (d > 100) d = 100;
		return d;
	endfunction

	function automatic sched_res_t predict_sched(logic [2:0] md, logic [5:0] sl,
			logic [6:0] np, logic [1:0] nx);
		sched_res_t r;
		int best;
		int bp;
		int d;
		int od;
		logic [63:0] s;
		logic [63:0] sum;
		r = '0;
		best = -1;
		bp = 0;
		case (md)
			pps_pkg::MODE_TICK: begin
				m_ticks = sinc(m_ticks);
				for (int i = 0; i < NSLOT; i++) begin
					if (m_st[i] == pps_pkg::SS_RUNNING) m_run[i] = sinc(m_run[i]);
					else if (m_st[i] == pps_pkg::SS_SLEEPING) m_slp[i] = sinc(m_slp[i]);
				end
			end
			pps_pkg::MODE_ALLOC: begin
				r.status = pps_pkg::RES_NONE;
				for (int i = 0; i < NSLOT; i++) begin
					if (r.status == pps_pkg::RES_NONE && m_st[i] == pps_pkg::SS_UNUSED) begin
						m_st[i] = pps_pkg::SS_RUNNABLE;
						m_prio[i] = m_def_prio;
						m_nice[i] = m_def_nice;
						m_runs[i] = '0;
						m_made[i] = m_ticks;
						m_slp[i] = '0;
						m_run[i] = '0;
						r.status = pps_pkg::RES_DONE;
						r.chosen = 6'(i);
					end
				end
			end
			pps_pkg::MODE_PICK: begin
				for (int i = 0; i < NSLOT; i++) begin
					if (m_st[i] == pps_pkg::SS_RUNNABLE) begin
						d = dprio(i);
						if (best < 0 || d < bp || (d == bp && (m_runs[i] < m_runs[best] ||
								(m_runs[i] == m_runs[best] && m_made[i] < m_made[best])))) begin
							best = i;
							bp = d;
						end
					end
				end
				if (best >= 0) begin
					m_st[best] = pps_pkg::SS_RUNNING;
					m_runs[best] = sinc(m_runs[best]);
					r.chosen = 6'(best);
				end else begin
					r.status = pps_pkg::RES_NONE;
				end
			end
			pps_pkg::MODE_REL: begin
				if (m_st[sl] != pps_pkg::SS_RUNNING || nx == pps_pkg::NXT_BAD) begin
					r.status = pps_pkg::RES_WRONG;
				end else begin
					s = {32'd0, m_slp[sl]};
					sum = s + {32'd0, m_run[sl]};
					m_st[sl] = (nx == pps_pkg::NXT_RUNNABLE) ? pps_pkg::SS_RUNNABLE :
						(nx == pps_pkg::NXT_SLEEPING) ? pps_pkg::SS_SLEEPING :
						pps_pkg::SS_EXITED;
					if (sum != 0) m_nice[sl] = 4'((64'd10 * s) / sum);
				end
			end
			pps_pkg::MODE_WAKE: begin
				if (m_st[sl] != pps_pkg::SS_SLEEPING) r.status = pps_pkg::RES_WRONG;
				else m_st[sl] = pps_pkg::SS_RUNNABLE;
			end
			pps_pkg::MODE_SETP: begin
				if (m_st[sl] == pps_pkg::SS_UNUSED) begin
					r.status = pps_pkg::RES_WRONG;
				end else begin
					od = int'(m_prio[sl]) - int'(m_nice[sl]) + 5;
					r.oldp = m_prio[sl];
					r.pre = (int'(np) < od);
					m_prio[sl] = np;
					m_nice[sl] = m_def_nice;
					m_slp[sl] = '0;
					m_run[sl] = '0;
				end
			end
			pps_pkg::MODE_FREE: begin
				if (m_st[sl] == pps_pkg::SS_UNUSED) r.status = pps_pkg::RES_WRONG;
				else m_st[sl] = pps_pkg::SS_UNUSED;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic send_cmd(logic [2:0] md, logic [5:0] sl, logic [6:0] np, logic [1:0] nx);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 15));
		do @(posedge clk); while (busy);
		repeat (gap) @(posedge clk);
		start <= 1'b1;
		mode <= md;
		slot <= sl;
		new_priority <= np;
		next_status <= nx;
		do @(posedge clk); while (busy);
		pending_res.push_back(predict_sched(md, sl, np, nx));
		start <= 1'b0;
	endtask

	task automatic wait_drain();
		while (pending_res.size() != 0) @(posedge clk);
		repeat (2 * NSLOT + 20) @(posedge clk);
	endtask

	task automatic write_reg(pps_pkg::reg_t idx, logic [31:0] val);
		logic [31:0] want;
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == pps_pkg::REG_DEF_PRIO) begin
			m_def_prio = val[6:0];
			want = {25'd0, val[6:0]};
		end else begin
			m_def_nice = val[3:0];
			want = {28'd0, val[3:0]};
		end
		@(posedge clk);
		if (prdata !== want) begin
			$display("%0t: expected register %0d actual %0d", $time, want, prdata);
			cfg_fail++;
		end
	endtask

	task automatic set_defaults(logic [6:0] p, logic [3:0] n);
		wait_drain();
		write_reg(pps_pkg::REG_DEF_PRIO, 32'(p));
		write_reg(pps_pkg::REG_DEF_NICE, 32'(n));
	endtask

	task automatic test_directed();
		send_cmd(pps_pkg::MODE_PICK, 0, 0, 0);
		send_cmd(pps_pkg::MODE_REL, 0, 0, pps_pkg::NXT_RUNNABLE);
		send_cmd(pps_pkg::MODE_WAKE, 63, 0, 0);
		send_cmd(pps_pkg::MODE_SETP, 5, 100, 0);
		send_cmd(pps_pkg::MODE_FREE, 0, 0, 0);
		send_cmd(pps_pkg::MODE_ALLOC, 0, 0, 0);
		send_cmd(pps_pkg::MODE_ALLOC, 0, 0, 0);
		send_cmd(pps_pkg::MODE_SETP, 1, 7'd127, 0);
		send_cmd(pps_pkg::MODE_SETP, 0, 0, 0);
		send_cmd(pps_pkg::MODE_PICK, 0, 0, 0);
		send_cmd(pps_pkg::MODE_TICK, 0, 0, 0);
		send_cmd(pps_pkg::MODE_REL, 0, 0, pps_pkg::NXT_BAD);
		send_cmd(pps_pkg::MODE_REL, 0, 0, pps_pkg::NXT_SLEEPING);
		send_cmd(pps_pkg::MODE_TICK, 0, 0, 0);
		send_cmd(pps_pkg::MODE_WAKE, 0, 0, 0);
		send_cmd(pps_pkg::MODE_PICK, 0, 0, 0);
		send_cmd(pps_pkg::MODE_REL, 1, 0, pps_pkg::NXT_EXITED);
		send_cmd(pps_pkg::MODE_NOP, 6'h3f, 7'h7f, 2'h3);
		send_cmd(pps_pkg::MODE_FREE, 1, 0, 0);
		send_cmd(pps_pkg::MODE_FREE, 1, 0, 0);
	endtask

	task automatic test_full_table();
		for (int i = 0; i < NSLOT + 1; i++) send_cmd(pps_pkg::MODE_ALLOC, 0, 0, 0);
		for (int i = 0; i < NSLOT; i++) send_cmd(pps_pkg::MODE_FREE, 6'(i), 0, 0);
	endtask

	task automatic test_random(int n);
		int k;
		logic [2:0] md;
		logic [5:0] sl;
		logic [6:0] np;
		logic [1:0] nx;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 99);
			if (k < 15) md = pps_pkg::MODE_TICK;
			else if (k < 30) md = pps_pkg::MODE_ALLOC;
			else if (k < 48) md = pps_pkg::MODE_PICK;
			else if (k < 68) md = pps_pkg::MODE_REL;
			else if (k < 78) md = pps_pkg::MODE_WAKE;
			else if (k < 86) md = pps_pkg::MODE_SETP;
			else if (k < 96) md = pps_pkg::MODE_FREE;
			else md = pps_pkg::MODE_NOP;
			sl = ($urandom_range(0, 3) != 0) ? 6'($urandom_range(0, 15)) :
				6'($urandom_range(0, 63));
			np = 7'($urandom_range(0, 127));
			nx = ($urandom_range(0, 9) == 0) ? pps_pkg::NXT_BAD : 2'($urandom_range(0, 2));
			send_cmd(md, sl, np, nx);
		end
	endtask

	always @(posedge clk) begin
		sched_res_t e;
		if (arst_n && done) begin
			if (pending_res.size() == 0) begin
				$display("%0t: unexpected transaction status=%0d", $time, status);
				fail_count++;
			end else begin
				e = pending_res.pop_front();
				if (status !== e.status || chosen_slot !== e.chosen ||
						old_priority !== e.oldp || preempt !== e.pre) begin
					$display("%0t: expected %0d/%0d/%0d/%0d actual %0d/%0d/%0d/%0d", $time,
						e.status, e.chosen, e.oldp, e.pre,
						status, chosen_slot, old_priority, preempt);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (done || (start && !busy) || psel) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCH_LIMIT) begin
			$display("priority_process_scheduler: mismatch");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		mode = '0;
		slot = '0;
		new_priority = '0;
		next_status = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		m_ticks = '0;
		m_def_prio = pps_pkg::DEF_PRIO_RST;
		m_def_nice = pps_pkg::DEF_NICE_RST;
		for (int i = 0; i < NSLOT; i++) begin
			m_st[i] = pps_pkg::SS_UNUSED;
			m_prio[i] = '0;
			m_nice[i] = '0;
			m_runs[i] = '0;
			m_made[i] = '0;
			m_slp[i] = '0;
			m_run[i] = '0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2 * NSLOT + 10) @(posedge clk);
		test_directed();
		test_full_table();
		set_defaults(0, 10);
		test_random(250);
		set_defaults(100, 0);
		test_random(250);
		set_defaults(7'd127, 4'd15);
		test_random(126);
		set_defaults(7'($urandom_range(0, 100)), 4'($urandom_range(0, 10)));
		test_random(126);
		wait_drain();
		if (fail_count == 0 && cfg_fail == 0) $display("priority_process_scheduler: match");
		else $display("priority_process_scheduler: mismatch");
		$finish;
	end
endmodule

/* filelist.f */
hdl/pps_pkg.sv
hdl/pps_cell.sv
hdl/pps_div.sv
hdl/priority_process_scheduler.sv
test/tb.sv
